### rtl/core/lau_pkg.sv
// Shared types and constants for the load accumulator addressing unit.
// No dependencies; used by the core, its result queue and its checker.
`timescale 1ns / 1ps
`default_nettype none
package lau_pkg;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_EXEC  = 2'd1;
  localparam logic [1:0] REQ_SET_X = 2'd2;
  localparam logic [1:0] REQ_SET_Y = 2'd3;

  localparam logic [7:0] OP_IMM  = 8'hA9;
  localparam logic [7:0] OP_ZP   = 8'hA5;
  localparam logic [7:0] OP_ZPX  = 8'hB5;
  localparam logic [7:0] OP_ABS  = 8'hAD;
  localparam logic [7:0] OP_ABSX = 8'hBD;
  localparam logic [7:0] OP_ABSY = 8'hB9;
  localparam logic [7:0] OP_INDX = 8'hA1;
  localparam logic [7:0] OP_INDY = 8'hB1;

  localparam logic RES_DONE        = 1'b0;
  localparam logic RES_UNSUPPORTED = 1'b1;

  // pages 0 and 1 are cleared after reset
  localparam int unsigned CLR_BITS = 9;
  localparam logic [CLR_BITS-1:0] CLR_LAST = 9'd511;

  localparam int unsigned SIGN_POS = 7;

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [15:0] pc;
    logic        zero;
    logic        neg;
    logic [7:0]  opcode;
    logic        code;
  } res_t;

endpackage
`default_nettype wire

### rtl/core/load_accumulator_addressing_unit_core.sv
// Top level of the load accumulator addressing unit: sequencer, registers,
// byte memory. Depends on lau_pkg, lau_ram and lau_outq.
//
// Usage:
//  - Input channel (in_valid/in_ready) takes one request: memory byte write,
//    set X, set Y, or execute one LDA instruction at the program counter.
//  - Result channel (out_valid/out_ready) returns one record per request:
//    registers and flags after it, fetched opcode and result code.
//  - cfg_wr_en/cfg_wr_data write the start address; the program counter is
//    loaded with it at once. Write only while the block is idle.
//  - Write and set requests finish at accept; a new request can follow in
//    the next cycle while the queue has room. Execute runs OP (an unsupported
//    opcode ends there), then DATA (immediate), OPLO, DATA (zero page),
//    OPLO, OPHI, DATA (absolute) or OPLO, PTRLO, PTRHI, DATA (indirect).
//    The result is queued in the last state; out_valid shows it in the next.
//  - in_ready stays low while an instruction runs, so no write can race it.
//  - Reset clears pages 0 and 1 of memory, one byte per cycle; in_ready is
//    low until the clear ends after rst_n rises. Registers reset to zero.
//  - A two-entry result queue absorbs a stalled receiver; in_ready also
//    drops when both entries are full.
`timescale 1ns / 1ps
`default_nettype none
module load_accumulator_addressing_unit_core #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [15:0] in_mem_address,
  input  wire logic [7:0]  in_write_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_accumulator_out,
  output logic [7:0]       out_index_x_out,
  output logic [7:0]       out_index_y_out,
  output logic [15:0]      out_pc_out,
  output logic             out_zero_out,
  output logic             out_negative_out,
  output logic [7:0]       out_opcode_out,
  output logic             out_result_code
);

  localparam int unsigned MEM_DEPTH = 2 ** ADDR_BITS;

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_OP    = 3'd2;
  localparam logic [2:0] ST_OPLO  = 3'd3;
  localparam logic [2:0] ST_OPHI  = 3'd4;
  localparam logic [2:0] ST_PTRLO = 3'd5;
  localparam logic [2:0] ST_PTRHI = 3'd6;
  localparam logic [2:0] ST_DATA  = 3'd7;

  logic [2:0]                   state_r, state_nxt;
  logic [15:0]                  pc_r, pc_nxt;
  logic [7:0]                   acc_r, acc_nxt;
  logic [7:0]                   x_r, x_nxt;
  logic [7:0]                   y_r, y_nxt;
  logic                         z_r, z_nxt;
  logic                         n_r, n_nxt;
  logic [7:0]                   opc_r, opc_nxt;
  logic [7:0]                   lo_r, lo_nxt;
  logic [7:0]                   ptr_r, ptr_nxt;
  logic [lau_pkg::CLR_BITS-1:0] clr_r, clr_nxt;

  logic [15:0]          rd_addr;
  logic [7:0]           rd_data;
  logic                 wr_en;
  logic [ADDR_BITS-1:0] wr_addr;
  logic [7:0]           wr_data;

  logic          accept;
  logic          q_room;
  logic          push;
  logic          push_bad;
  lau_pkg::res_t push_data;
  lau_pkg::res_t out_data;
  logic [7:0]    zp_x;
  logic [15:0]   word;

  assign in_ready = (state_r == ST_IDLE) && q_room;
  assign accept   = in_valid && in_ready;
  assign zp_x     = rd_data + x_r;
  assign word     = {rd_data, lo_r};

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    acc_nxt   = acc_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    n_nxt     = n_r;
    opc_nxt   = opc_r;
    lo_nxt    = lo_r;
    ptr_nxt   = ptr_r;
    clr_nxt   = clr_r;
    rd_addr   = pc_r;
    wr_en     = 1'b0;
    wr_addr   = in_mem_address[ADDR_BITS-1:0];
    wr_data   = in_write_value;
    push      = 1'b0;
    push_bad  = 1'b0;

    unique case (state_r)
      ST_CLR: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_BITS'(clr_r);
        wr_data = 8'd0;
        clr_nxt = clr_r + {{(lau_pkg::CLR_BITS-1){1'b0}}, 1'b1};
        if (clr_r == lau_pkg::CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        opc_nxt = 8'd0;
        if (accept) begin
          unique case (in_req_type)
            lau_pkg::REQ_WRITE: begin
              wr_en = 1'b1;
              push  = 1'b1;
            end
            lau_pkg::REQ_SET_X: begin
              x_nxt = in_write_value;
              push  = 1'b1;
            end
            lau_pkg::REQ_SET_Y: begin
              y_nxt = in_write_value;
              push  = 1'b1;
            end
            lau_pkg::REQ_EXEC: begin
              rd_addr   = pc_r;
              pc_nxt    = pc_r + 16'd1;
              state_nxt = ST_OP;
            end
          endcase
        end
      end
      ST_OP: begin
        opc_nxt = rd_data;
        rd_addr = pc_r;
        unique case (rd_data)
          lau_pkg::OP_IMM: begin
            pc_nxt    = pc_r + 16'd1;
            state_nxt = ST_DATA;
          end
          lau_pkg::OP_ZP, lau_pkg::OP_ZPX, lau_pkg::OP_ABS, lau_pkg::OP_ABSX,
          lau_pkg::OP_ABSY, lau_pkg::OP_INDX, lau_pkg::OP_INDY: begin
            pc_nxt    = pc_r + 16'd1;
            state_nxt = ST_OPLO;
          end
          default: begin
            push      = 1'b1;
            push_bad  = 1'b1;
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_OPLO: begin
        lo_nxt = rd_data;
        unique case (opc_r)
          lau_pkg::OP_ZP: begin
            rd_addr   = {8'd0, rd_data};
            state_nxt = ST_DATA;
          end
          lau_pkg::OP_ZPX: begin
            rd_addr   = {8'd0, zp_x};
            state_nxt = ST_DATA;
          end
          lau_pkg::OP_INDX: begin
            rd_addr   = {8'd0, zp_x};
            ptr_nxt   = zp_x + 8'd1;
            state_nxt = ST_PTRLO;
          end
          lau_pkg::OP_INDY: begin
            rd_addr   = {8'd0, rd_data};
            ptr_nxt   = rd_data + 8'd1;
            state_nxt = ST_PTRLO;
          end
          default: begin
            rd_addr   = pc_r;
            pc_nxt    = pc_r + 16'd1;
            state_nxt = ST_OPHI;
          end
        endcase
      end
      ST_OPHI: begin
        if (opc_r == lau_pkg::OP_ABSX) begin
          rd_addr = word + {8'd0, x_r};
        end else if (opc_r == lau_pkg::OP_ABSY) begin
          rd_addr = word + {8'd0, y_r};
        end else begin
          rd_addr = word;
        end
        state_nxt = ST_DATA;
      end
      ST_PTRLO: begin
        lo_nxt    = rd_data;
        rd_addr   = {8'd0, ptr_r};
        state_nxt = ST_PTRHI;
      end
      ST_PTRHI: begin
        if (opc_r == lau_pkg::OP_INDY) begin
          rd_addr = word + {8'd0, y_r};
        end else begin
          rd_addr = word;
        end
        state_nxt = ST_DATA;
      end
      ST_DATA: begin
        acc_nxt   = rd_data;
        z_nxt     = (rd_data == 8'd0);
        n_nxt     = rd_data[lau_pkg::SIGN_POS];
        push      = 1'b1;
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_wr_en) begin
      pc_nxt = cfg_wr_data;
    end
  end

  always_comb begin
    push_data.acc    = acc_nxt;
    push_data.x      = x_nxt;
    push_data.y      = y_nxt;
    push_data.pc     = pc_nxt;
    push_data.zero   = z_nxt;
    push_data.neg    = n_nxt;
    push_data.opcode = opc_nxt;
    push_data.code   = push_bad ? lau_pkg::RES_UNSUPPORTED : lau_pkg::RES_DONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_r   <= '0;
      pc_r    <= 16'd0;
      acc_r   <= 8'd0;
      x_r     <= 8'd0;
      y_r     <= 8'd0;
      z_r     <= 1'b0;
      n_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      pc_r    <= pc_nxt;
      acc_r   <= acc_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      z_r     <= z_nxt;
      n_r     <= n_nxt;
    end
    opc_r <= opc_nxt;
    lo_r  <= lo_nxt;
    ptr_r <= ptr_nxt;
  end

  lau_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr[ADDR_BITS-1:0]),
    .rdata (rd_data)
  );

  lau_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .room      (q_room)
  );

  assign out_accumulator_out = out_data.acc;
  assign out_index_x_out     = out_data.x;
  assign out_index_y_out     = out_data.y;
  assign out_pc_out          = out_data.pc;
  assign out_zero_out        = out_data.zero;
  assign out_negative_out    = out_data.neg;
  assign out_opcode_out      = out_data.opcode;
  assign out_result_code     = out_data.code;

endmodule
`default_nettype wire

### rtl/core/lau_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lau_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/core/lau_outq.sv
// Two-entry result queue between the core sequencer and the result channel.
// Depends on lau_pkg for the result record.
`timescale 1ns / 1ps
`default_nettype none
module lau_outq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire lau_pkg::res_t push_data,
  input  wire logic          out_ready,
  output logic               out_valid,
  output lau_pkg::res_t      out_data,
  output logic               room
);

  lau_pkg::res_t slot0_r, slot0_nxt;
  lau_pkg::res_t slot1_r, slot1_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot0_r;
  assign room      = (cnt_r != 2'd2);
  assign pop       = out_valid && out_ready;

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    priority if (push && !pop) begin
      if (cnt_r == 2'd0) begin
        slot0_nxt = push_data;
      end else begin
        slot1_nxt = push_data;
      end
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end else if (pop && push) begin
      if (cnt_r == 2'd1) begin
        slot0_nxt = push_data;
      end else begin
        slot0_nxt = slot1_r;
        slot1_nxt = push_data;
      end
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule
`default_nettype wire

### rtl/core/lau_checker.sv
// Port-level checker for the load accumulator addressing unit, bound to the
// top level. Depends on lau_pkg for opcode constants.
`timescale 1ns / 1ps
`default_nettype none
module lau_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_accumulator_out,
  input wire logic [7:0]  out_index_x_out,
  input wire logic [7:0]  out_index_y_out,
  input wire logic [15:0] out_pc_out,
  input wire logic        out_zero_out,
  input wire logic        out_negative_out,
  input wire logic [7:0]  out_opcode_out,
  input wire logic        out_result_code
);

  // memory clear runs right after reset
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready during memory clear");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_zero_out && out_negative_out))
    else $error("zero and negative flags both set");

  a_unsupported_opcode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_code) |->
      (out_opcode_out != lau_pkg::OP_IMM  && out_opcode_out != lau_pkg::OP_ZP &&
       out_opcode_out != lau_pkg::OP_ZPX  && out_opcode_out != lau_pkg::OP_ABS &&
       out_opcode_out != lau_pkg::OP_ABSX && out_opcode_out != lau_pkg::OP_ABSY &&
       out_opcode_out != lau_pkg::OP_INDX && out_opcode_out != lau_pkg::OP_INDY))
    else $error("supported opcode flagged unsupported");

  a_out_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before transfer");

  a_out_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      $stable({out_accumulator_out, out_index_x_out, out_index_y_out, out_pc_out,
               out_zero_out, out_negative_out, out_opcode_out, out_result_code}))
    else $error("result changed before transfer");

endmodule

bind load_accumulator_addressing_unit_core lau_checker u_lau_checker (.*);
`default_nettype wire
